/* design/vcf_pkg.sv */
`timescale 1ns / 1ps

package vcf_pkg;

    localparam int CELL_COUNT = 64;

    localparam logic [3:0] OP_SET_VOXEL   = 4'd0;
    localparam logic [3:0] OP_CLEAR_VOXEL = 4'd1;
    localparam logic [3:0] OP_READ_VOXEL  = 4'd2;
    localparam logic [3:0] OP_SET_PLANE   = 4'd3;
    localparam logic [3:0] OP_SHIFT       = 4'd4;
    localparam logic [3:0] OP_CLEAR_ALL   = 4'd5;
    localparam logic [3:0] OP_FILL_ALL    = 4'd6;
    localparam logic [3:0] OP_DRAW_CUBE   = 4'd7;
    localparam logic [3:0] OP_RENDER      = 4'd8;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] DIR_POS_X = 3'd0;
    localparam logic [2:0] DIR_NEG_X = 3'd1;
    localparam logic [2:0] DIR_POS_Z = 3'd2;
    localparam logic [2:0] DIR_NEG_Z = 3'd3;
    localparam logic [2:0] DIR_POS_Y = 3'd4;
    localparam logic [2:0] DIR_NEG_Y = 3'd5;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_LAYER = 2'd2;

    typedef struct packed {
        logic [3:0] operation;
        logic [2:0] x_coord;
        logic [2:0] y_coord;
        logic [2:0] z_coord;
        logic [1:0] plane_axis;
        logic [2:0] plane_index;
        logic [2:0] shift_direction;
        logic [3:0] edge_size;
    } vcf_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        voxel_lit;
        logic [7:0]  layer_select;
        logic [63:0] layer_data;
        logic        last_result;
    } vcf_out_t;

endpackage

/* design/vcf_frame_ram.sv */
`timescale 1ns / 1ps

module vcf_frame_ram (
    input  logic       aclk,
    input  logic       wr_en,
    input  logic [5:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [5:0] rd_addr,
    output logic [7:0] rd_data
);
    import vcf_pkg::*;

    logic [7:0] mem [CELL_COUNT];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/vcf_byte_alu.sv */
`timescale 1ns / 1ps

module vcf_byte_alu (
    input  vcf_pkg::vcf_in_t cmd,
    input  logic [5:0]       dest,
    input  logic [7:0]       old_byte,
    input  logic             zero_fill,
    output logic [7:0]       new_byte,
    output logic             wr_en
);
    import vcf_pkg::*;

    logic [4:0] lo_x, lo_y, lo_z;
    logic [4:0] hi_x, hi_y, hi_z;
    logic [2:0] byte_y, byte_z;
    logic       y_edge, y_span, z_edge, z_span;
    logic [7:0] cube_mask;
    logic [7:0] x_bit;

    function automatic logic on_edge(input logic [2:0] v, input logic [4:0] lo,
                                     input logic [4:0] hi);
        logic [4:0] w;
        w = {2'b00, v};
        return (w == lo) || (w == hi);
    endfunction

    function automatic logic in_span(input logic [2:0] v, input logic [4:0] lo,
                                     input logic [4:0] hi);
        logic [4:0] w;
        w = {2'b00, v};
        return (w >= lo) && (w <= hi);
    endfunction

    assign lo_x = {2'b00, cmd.x_coord};
    assign lo_y = {2'b00, cmd.y_coord};
    assign lo_z = {2'b00, cmd.z_coord};
    assign hi_x = lo_x + {1'b0, cmd.edge_size} - 5'd1;
    assign hi_y = lo_y + {1'b0, cmd.edge_size} - 5'd1;
    assign hi_z = lo_z + {1'b0, cmd.edge_size} - 5'd1;

    // Row is 7 - y and column is 7 - z, so the coordinates are the inverted fields.
    assign byte_y = ~dest[5:3];
    assign byte_z = ~dest[2:0];
    assign y_edge = on_edge(byte_y, lo_y, hi_y);
    assign y_span = in_span(byte_y, lo_y, hi_y);
    assign z_edge = on_edge(byte_z, lo_z, hi_z);
    assign z_span = in_span(byte_z, lo_z, hi_z);
    assign x_bit  = 8'b1 << cmd.x_coord;

    // A voxel lies on a cube edge when two coordinates sit on a face and the
    // third lies within the span.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            cube_mask[i] = (on_edge(3'(i), lo_x, hi_x) && z_edge && y_span)
                        || (on_edge(3'(i), lo_x, hi_x) && y_edge && z_span)
                        || (y_edge && z_edge && in_span(3'(i), lo_x, hi_x));
        end
    end

    always_comb begin
        new_byte = old_byte;
        wr_en    = 1'b1;
        case (cmd.operation)
            OP_SET_VOXEL: begin
                new_byte = old_byte | x_bit;
            end
            OP_CLEAR_VOXEL: begin
                new_byte = old_byte & ~x_bit;
            end
            OP_READ_VOXEL: begin
                wr_en = 1'b0;
            end
            OP_SET_PLANE: begin
                case (cmd.plane_axis)
                    AXIS_X: new_byte = old_byte | (8'b1 << cmd.plane_index);
                    AXIS_Y: if (dest[5:3] == ~cmd.plane_index) new_byte = 8'hFF;
                    AXIS_Z: if (dest[2:0] == ~cmd.plane_index) new_byte = 8'hFF;
                    default: new_byte = old_byte;
                endcase
            end
            OP_SHIFT: begin
                case (cmd.shift_direction)
                    DIR_POS_X: new_byte = old_byte << 1;
                    DIR_NEG_X: new_byte = old_byte >> 1;
                    DIR_POS_Z, DIR_NEG_Z, DIR_POS_Y, DIR_NEG_Y: begin
                        new_byte = zero_fill ? 8'h00 : old_byte;
                    end
                    default: new_byte = old_byte;
                endcase
            end
            OP_CLEAR_ALL: begin
                new_byte = 8'h00;
            end
            OP_FILL_ALL: begin
                new_byte = 8'hFF;
            end
            OP_DRAW_CUBE: begin
                if (cmd.edge_size != 4'd0) begin
                    new_byte = old_byte | cube_mask;
                end
            end
            OP_RENDER: begin
                wr_en = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

endmodule

/* design/voxel_cube_frame_engine.sv */
`timescale 1ns / 1ps
// Voxel ops (set, clear, read) visit only the addressed byte, then give a result word.
// Plane, shift, clear, fill and cube commands sweep the 64-byte frame RAM one
// byte a cycle, through its one read port and one write port, then give an ack word.
// Render reads one byte a cycle within a layer and emits eight layer words; before
// each layer it waits until the pipeline and the result register are empty.
// After aresetn all 64 bytes of the RAM are cleared before the first word is taken.
module voxel_cube_frame_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vcf_pkg::vcf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vcf_pkg::vcf_out_t m_data
);
    import vcf_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_ACK  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    vcf_in_t    cmd_reg, cmd_next;
    logic       p_valid_reg, p_valid_next;
    logic [5:0] p_dest_reg, p_dest_next;
    logic       p_zero_reg, p_zero_next;
    logic       lit_reg, lit_next;
    logic [55:0] acc_reg, acc_next;
    logic       m_valid_reg, m_valid_next;
    vcf_out_t   m_data_reg, m_data_next;

    logic       is_render, single_step, descending, issue;
    logic [6:0] step_count;
    logic [5:0] dest, src;
    logic       zero_fill;
    logic [7:0] rd_data, alu_byte;
    logic       alu_wr;
    logic       ram_we;
    logic [5:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic       ld_layer, ld_ack;

    vcf_frame_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (src),
        .rd_data (rd_data)
    );

    vcf_byte_alu u_alu (
        .cmd       (cmd_reg),
        .dest      (p_dest_reg),
        .old_byte  (rd_data),
        .zero_fill (p_zero_reg),
        .new_byte  (alu_byte),
        .wr_en     (alu_wr)
    );

    assign is_render = (cmd_reg.operation == OP_RENDER);

    always_comb begin
        single_step = 1'b1;
        if (cmd_reg.operation inside {[OP_SET_PLANE:OP_RENDER]}) begin
            single_step = 1'b0;
        end
    end

    assign step_count = single_step ? 7'd1 : 7'(CELL_COUNT);
    assign descending = (cmd_reg.operation == OP_SHIFT)
                     && (cmd_reg.shift_direction == DIR_NEG_Z
                         || cmd_reg.shift_direction == DIR_NEG_Y);

    // Shifts that pull from a lower address sweep downward and all other sweeps run
    // upward, so a source byte is always read before it is overwritten.
    always_comb begin
        if (single_step) begin
            dest = {~cmd_reg.y_coord, ~cmd_reg.z_coord};
        end else if (descending) begin
            dest = ~cnt_reg[5:0];
        end else begin
            dest = cnt_reg[5:0];
        end
        src       = dest;
        zero_fill = 1'b0;
        if (cmd_reg.operation == OP_SHIFT) begin
            case (cmd_reg.shift_direction)
                DIR_POS_Z: begin
                    src       = dest + 6'd1;
                    zero_fill = (dest[2:0] == 3'd7);
                end
                DIR_NEG_Z: begin
                    src       = dest - 6'd1;
                    zero_fill = (dest[2:0] == 3'd0);
                end
                DIR_POS_Y: begin
                    src       = dest + 6'd8;
                    zero_fill = (dest[5:3] == 3'd7);
                end
                DIR_NEG_Y: begin
                    src       = dest - 6'd8;
                    zero_fill = (dest[5:3] == 3'd0);
                end
                default: begin
                    src = dest;
                end
            endcase
        end
    end

    // Render starts each layer only with an empty pipeline and result register,
    // so the finished layer always finds the register free.
    assign issue = (state_reg == ST_RUN) && (cnt_reg != step_count)
                && (!is_render || cnt_reg[2:0] != 3'd0
                    || (!m_valid_reg && !p_valid_reg));

    assign ld_layer = p_valid_reg && is_render && (p_dest_reg[2:0] == 3'd7);
    assign ld_ack   = (state_reg == ST_ACK) && (!m_valid_reg || m_ready);

    always_comb begin
        if (state_reg == ST_INIT) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[5:0];
            ram_wdata = 8'h00;
        end else begin
            ram_we    = p_valid_reg && alu_wr;
            ram_waddr = p_dest_reg;
            ram_wdata = alu_byte;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        p_valid_next = issue;
        p_dest_next  = dest;
        p_zero_next  = zero_fill;
        lit_next     = lit_reg;
        acc_next     = acc_reg;
        s_ready      = 1'b0;

        if (p_valid_reg) begin
            lit_next = rd_data[cmd_reg.x_coord];
            acc_next = {acc_reg[47:0], rd_data};
        end

        case (state_reg)
            ST_INIT: begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[5:0] == 6'h3F) begin
                    cnt_next   = 7'd0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_data;
                    cnt_next   = 7'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    cnt_next = cnt_reg + 7'd1;
                end
                if (cnt_reg == step_count && !p_valid_reg) begin
                    state_next = is_render ? ST_IDLE : ST_ACK;
                end
            end
            ST_ACK: begin
                if (ld_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ld_layer) begin
            m_valid_next              = 1'b1;
            m_data_next.result_kind   = KIND_LAYER;
            m_data_next.voxel_lit     = 1'b0;
            m_data_next.layer_select  = 8'b1 << p_dest_reg[5:3];
            m_data_next.layer_data    = {acc_reg, rd_data};
            m_data_next.last_result   = (p_dest_reg[5:3] == 3'd7);
        end
        if (ld_ack) begin
            m_valid_next              = 1'b1;
            m_data_next.layer_select  = 8'h00;
            m_data_next.layer_data    = 64'h0;
            m_data_next.last_result   = 1'b1;
            if (cmd_reg.operation == OP_READ_VOXEL) begin
                m_data_next.result_kind = KIND_READ;
                m_data_next.voxel_lit   = lit_reg;
            end else begin
                m_data_next.result_kind = KIND_ACK;
                m_data_next.voxel_lit   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            cnt_reg     <= 7'd0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        p_dest_reg <= p_dest_next;
        p_zero_reg <= p_zero_next;
        lit_reg    <= lit_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
